// ----- hw/rtl/qsfd_pkg.sv -----
// types, character codes and helpers shared by the quoted string field decoder
`default_nettype none

package qsfd_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_STR,
        PH_ESC_HI,
        PH_ESC_LO,
        PH_CLOSED
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_OK,
        KIND_ERR
    } kind_t;

    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] HEX_TEN   = 8'd10;

    localparam logic [7:0] MAX_LENGTH_RESET = 8'd255;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t       h;
        logic [7:0] t;
        begin
            h.ok    = 1'b0;
            h.value = 4'd0;
            t       = 8'd0;
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                t       = c - CH_ZERO;
                h.ok    = 1'b1;
                h.value = t[3:0];
            end
            else if (c >= CH_LOW_A && c <= CH_LOW_F)
            begin
                t       = c - CH_LOW_A + HEX_TEN;
                h.ok    = 1'b1;
                h.value = t[3:0];
            end
            else if (c >= CH_UP_A && c <= CH_UP_F)
            begin
                t       = c - CH_UP_A + HEX_TEN;
                h.ok    = 1'b1;
                h.value = t[3:0];
            end
            return h;
        end
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/quoted_string_field_decoder.sv -----
// quoted string field decoder top level
`default_nettype none

// Decodes one quoted string parameter of a command line, one character per
// transfer on the input channel. The block takes one character every clock
// cycle: the decode of a character is a single registered stage, so its
// result (a decoded byte, field ok, or field error) is offered on the output
// channel in the cycle after the character is taken, and characters that
// cause no result simply update the field state. in_ready is low only while
// a result sits in the output register and out_ready is low. max_length may
// be written through cfg_write_en/cfg_write_data while no field is in
// progress; it resets to 255.
module quoted_string_field_decoder
    import qsfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       cfg_write_en,
    input  wire logic [7:0] cfg_write_data,

    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] ch,
    input  wire logic       field_start,
    input  wire logic       line_end,

    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      kind,
    output logic [7:0]      data,
    output logic [7:0]      count
);

    phase_t     phase_reg, phase_next;
    logic [7:0] byte_count_reg, byte_count_next;
    logic [3:0] high_nibble_reg, high_nibble_next;
    logic [7:0] max_length_reg;

    logic       out_valid_reg, out_valid_next;
    kind_t      kind_reg, kind_next;
    logic [7:0] data_reg, data_next;
    logic [7:0] count_reg, count_next;

    logic       accept;
    logic       full;
    logic       first_empty;
    hex_t       hex;
    logic [7:0] esc_byte;
    logic [7:0] count_inc;

    assign in_ready    = !out_valid_reg || out_ready;
    assign accept      = in_valid && in_ready;
    assign full        = byte_count_reg >= max_length_reg;
    assign first_empty = line_end || ch == CH_COMMA || ch == CH_SEMI;
    assign hex         = hex_decode(ch);
    assign esc_byte    = {high_nibble_reg, hex.value};
    assign count_inc   = byte_count_reg + 8'd1;

    // next state
    always_comb
    begin
        phase_next       = phase_reg;
        byte_count_next  = byte_count_reg;
        high_nibble_next = high_nibble_reg;
        if (field_start)
        begin
            byte_count_next  = 8'd0;
            high_nibble_next = 4'd0;
            phase_next       = (!first_empty && ch == CH_QUOTE) ? PH_STR : PH_IDLE;
        end
        else
        begin
            case (phase_reg)
                PH_STR:
                begin
                    if (line_end)
                        phase_next = PH_IDLE;
                    else if (ch == CH_QUOTE)
                        phase_next = PH_CLOSED;
                    else if (ch == CH_BSLASH)
                        phase_next = PH_ESC_HI;
                    else if (full)
                        phase_next = PH_IDLE;
                    else
                        byte_count_next = count_inc;
                end
                PH_ESC_HI:
                begin
                    if (line_end || !hex.ok)
                        phase_next = PH_IDLE;
                    else
                    begin
                        high_nibble_next = hex.value;
                        phase_next       = PH_ESC_LO;
                    end
                end
                PH_ESC_LO:
                begin
                    if (line_end || !hex.ok || full)
                        phase_next = PH_IDLE;
                    else
                    begin
                        byte_count_next = count_inc;
                        phase_next      = PH_STR;
                    end
                end
                default:
                    phase_next = PH_IDLE;
            endcase
        end
    end

    // result of the current character
    always_comb
    begin
        out_valid_next = 1'b0;
        kind_next      = KIND_ERR;
        data_next      = 8'd0;
        count_next     = byte_count_reg;
        if (field_start)
        begin
            count_next = 8'd0;
            if (first_empty)
            begin
                out_valid_next = 1'b1;
                kind_next      = KIND_OK;
            end
            else if (ch != CH_QUOTE)
                out_valid_next = 1'b1;
        end
        else
        begin
            case (phase_reg)
                PH_STR:
                begin
                    if (line_end)
                        out_valid_next = 1'b1;
                    else if (ch == CH_QUOTE)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = KIND_OK;
                    end
                    else if (ch == CH_BSLASH)
                        out_valid_next = 1'b0;
                    else if (full)
                        out_valid_next = 1'b1;
                    else
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = KIND_BYTE;
                        data_next      = ch;
                        count_next     = count_inc;
                    end
                end
                PH_ESC_HI:
                    out_valid_next = line_end || !hex.ok;
                PH_ESC_LO:
                begin
                    out_valid_next = 1'b1;
                    if (!(line_end || !hex.ok || full))
                    begin
                        kind_next  = KIND_BYTE;
                        data_next  = esc_byte;
                        count_next = count_inc;
                    end
                end
                default:
                    out_valid_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            byte_count_reg  <= 8'd0;
            high_nibble_reg <= 4'd0;
            max_length_reg  <= MAX_LENGTH_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
                max_length_reg <= cfg_write_data;
            if (accept)
            begin
                phase_reg       <= phase_next;
                byte_count_reg  <= byte_count_next;
                high_nibble_reg <= high_nibble_next;
                out_valid_reg   <= out_valid_next;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept && out_valid_next)
        begin
            kind_reg  <= kind_next;
            data_reg  <= data_next;
            count_reg <= count_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign data      = data_reg;
    assign count     = count_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/qsfd_checker.sv -----
// port-level checks for the quoted string field decoder, with bind
`default_nettype none

module qsfd_checker
    import qsfd_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       field_start,
    input wire logic       line_end,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] kind,
    input wire logic [7:0] data,
    input wire logic [7:0] count
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(data)
            && $stable(count))
        else $error("result changed while stalled");

    // a waiting result blocks new input
    a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result waits");

    // only decoded bytes carry data
    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_BYTE |-> data == 8'd0)
        else $error("nonzero data on status result");

    // a decoded byte always counts at least one
    a_byte_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_BYTE |-> count != 8'd0)
        else $error("decoded byte with zero count");

    // terminator as first character is an empty field
    a_empty_field: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && field_start && line_end |=>
            out_valid && kind == KIND_OK && count == 8'd0)
        else $error("empty field not reported");

endmodule

bind quoted_string_field_decoder qsfd_checker u_qsfd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .field_start (field_start),
    .line_end    (line_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .data        (data),
    .count       (count)
);

`default_nettype wire

// ----- bench/tb.sv -----
// testbench for the quoted string field decoder: queued character driver, predictor and checker
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qsfd_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 100;
    localparam int IDLE_PCT    = 26;
    localparam int RX_HOLD     = 80;

    typedef struct packed {
        logic [7:0] c;
        logic       s;
        logic       t;
    } char_item_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [7:0] count;
    } decoded_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_write_en = 1'b0;
    logic [7:0] cfg_write_data = 8'd0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] ch = 8'd0;
    logic       field_start = 1'b0;
    logic       line_end = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] count;

    char_item_t line_chars[$];
    decoded_t   decoded_expect[$];

    phase_t     fld_phase = PH_IDLE;
    logic [7:0] fld_count = 8'd0;
    logic [3:0] fld_nibble = 4'd0;
    logic [7:0] max_len = MAX_LENGTH_RESET;

    logic       in_taken = 1'b0;
    bit         steady = 1'b0;
    bit         rx_stall_req = 1'b0;
    bit         rx_stall_done = 1'b0;
    int         rx_hold = 0;
    int         stall_cycles = 0;
    int         errors = 0;

    quoted_string_field_decoder dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .ch             (ch),
        .field_start    (field_start),
        .line_end       (line_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .data           (data),
        .count          (count)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
        logic [7:0] d;
        d = 8'd0;
        if (c >= CH_ZERO && c <= CH_NINE)
            d = c - CH_ZERO;
        else if (c >= CH_LOW_A && c <= CH_LOW_F)
            d = c - CH_LOW_A + HEX_TEN;
        else if (c >= CH_UP_A && c <= CH_UP_F)
            d = c - CH_UP_A + HEX_TEN;
        else
        begin
            v = 4'd0;
            return 1'b0;
        end
        v = d[3:0];
        return 1'b1;
    endfunction

    function automatic bit field_fail(output decoded_t r);
        fld_phase = PH_IDLE;
        r.kind  = KIND_ERR;
        r.data  = 8'd0;
        r.count = fld_count;
        return 1'b1;
    endfunction

    function automatic bit append_byte(input logic [7:0] b, output decoded_t r);
        if (fld_count >= max_len)
            return field_fail(r);
        fld_count = fld_count + 8'd1;
        fld_phase = PH_STR;
        r.kind  = KIND_BYTE;
        r.data  = b;
        r.count = fld_count;
        return 1'b1;
    endfunction

    // returns 1 when the character produces a result
    function automatic bit decode_char(input logic [7:0] c, input logic s, input logic t,
                                       output decoded_t r);
        logic [3:0] v;
        r.kind  = KIND_OK;
        r.data  = 8'd0;
        r.count = 8'd0;
        if (s)
        begin
            fld_count  = 8'd0;
            fld_nibble = 4'd0;
            fld_phase  = PH_IDLE;
            if (t || c == CH_COMMA || c == CH_SEMI)
                return 1'b1;
            if (c == CH_QUOTE)
            begin
                fld_phase = PH_STR;
                return 1'b0;
            end
            r.kind = KIND_ERR;
            return 1'b1;
        end
        case (fld_phase)
            PH_STR:
            begin
                if (t)
                    return field_fail(r);
                if (c == CH_QUOTE)
                begin
                    fld_phase = PH_CLOSED;
                    r.count   = fld_count;
                    return 1'b1;
                end
                if (c == CH_BSLASH)
                begin
                    fld_phase = PH_ESC_HI;
                    return 1'b0;
                end
                return append_byte(c, r);
            end
            PH_ESC_HI:
            begin
                if (t || !hex_nibble(c, v))
                    return field_fail(r);
                fld_nibble = v;
                fld_phase  = PH_ESC_LO;
                return 1'b0;
            end
            PH_ESC_LO:
            begin
                if (t || !hex_nibble(c, v))
                    return field_fail(r);
                return append_byte({fld_nibble, v}, r);
            end
            default:
            begin
                fld_phase = PH_IDLE;
                return 1'b0;
            end
        endcase
    endfunction

    // driver
    always @(negedge clk)
    begin
        char_item_t nxt;
        if (!in_valid || in_taken)
        begin
            if (line_chars.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
            begin
                nxt = line_chars.pop_front();
                ch          <= nxt.c;
                field_start <= nxt.s;
                line_end    <= nxt.t;
                in_valid    <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rx_hold != 0)
        begin
            rx_hold   <= rx_hold - 1;
            out_ready <= 1'b0;
        end
        else if (rx_stall_req && !rx_stall_done)
        begin
            rx_hold       <= RX_HOLD;
            rx_stall_done <= 1'b1;
            out_ready     <= 1'b0;
        end
        else
            out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // monitor and checker
    always @(posedge clk)
    begin
        decoded_t got;
        decoded_t want;
        bit       has;
        if (rst_n)
        begin
            in_taken <= in_valid && in_ready;
            if (out_valid && out_ready)
            begin
                if (decoded_expect.size() == 0)
                begin
                    $error("unexpected result: kind %0d data %0h count %0d", kind, data, count);
                    errors++;
                end
                else
                begin
                    want = decoded_expect.pop_front();
                    if (kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, kind);
                        errors++;
                    end
                    if (data !== want.data)
                    begin
                        $error("data: expected %0h, got %0h", want.data, data);
                        errors++;
                    end
                    if (count !== want.count)
                    begin
                        $error("count: expected %0d, got %0d", want.count, count);
                        errors++;
                    end
                end
            end
            if (cfg_write_en)
                max_len = cfg_write_data;
            if (in_valid && in_ready)
            begin
                has = decode_char(ch, field_start, line_end, got);
                if (has)
                    decoded_expect.push_back(got);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic push_char(input logic [7:0] c, input logic s, input logic t);
        char_item_t it;
        it.c = c;
        it.s = s;
        it.t = t;
        line_chars.push_back(it);
    endtask

    function automatic logic [7:0] rand_hex_char();
        case ($urandom_range(2))
            0:       return CH_ZERO + 8'($urandom_range(9));
            1:       return CH_LOW_A + 8'($urandom_range(5));
            default: return CH_UP_A + 8'($urandom_range(5));
        endcase
    endfunction

    function automatic logic [7:0] rand_bad_hex();
        logic [7:0] c;
        logic [3:0] v;
        do
            c = 8'($urandom_range(255));
        while (hex_nibble(c, v));
        return c;
    endfunction

    task automatic add_string(input int len, input bit close, input bit clean);
        int         r;
        logic [7:0] c;
        push_char(CH_QUOTE, 1'b1, 1'b0);
        for (int i = 0; i < len; i++)
        begin
            r = $urandom_range(99);
            if (r < 78)
            begin
                do
                    c = 8'($urandom_range(255));
                while (c == CH_QUOTE || c == CH_BSLASH);
                push_char(c, 1'b0, 1'b0);
            end
            else if (r < 95 || clean)
            begin
                push_char(CH_BSLASH, 1'b0, 1'b0);
                push_char(rand_hex_char(), 1'b0, 1'b0);
                push_char(rand_hex_char(), 1'b0, 1'b0);
            end
            else
            begin
                push_char(CH_BSLASH, 1'b0, 1'b0);
                if ($urandom_range(1))
                    push_char(rand_bad_hex(), 1'b0, 1'b0);
                else
                begin
                    push_char(rand_hex_char(), 1'b0, 1'b0);
                    push_char(rand_bad_hex(), 1'b0, 1'b0);
                end
                return;
            end
        end
        if (close)
        begin
            push_char(CH_QUOTE, 1'b0, 1'b0);
            if ($urandom_range(1))
                push_char(CH_COMMA, 1'b0, 1'b0);
        end
        else if ($urandom_range(1))
            push_char(CH_BSLASH, 1'b0, 1'b0);
    endtask

    task automatic add_line();
        int         r;
        int         len;
        logic [7:0] c;
        for (int f = $urandom_range(1, 4); f > 0; f--)
        begin
            r   = $urandom_range(99);
            len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
            if (r < 65)
                add_string(len, $urandom_range(99) < 92, 1'b0);
            else if (r < 75)
                push_char(CH_COMMA, 1'b1, 1'b0);
            else if (r < 80)
                push_char(CH_SEMI, 1'b1, 1'b0);
            else if (r < 85)
            begin
                do
                    c = 8'($urandom_range(255));
                while (c == CH_COMMA || c == CH_SEMI || c == CH_QUOTE);
                push_char(c, 1'b1, 1'b0);
            end
            else if (r < 90)
                add_string($urandom_range(4), 1'b0, 1'b0);
            else
                for (int n = $urandom_range(1, 4); n > 0; n--)
                    push_char(8'($urandom_range(255)), $urandom_range(99) < 20,
                              $urandom_range(99) < 10);
        end
        push_char(8'($urandom_range(255)), $urandom_range(99) < 30, 1'b1);
    endtask

    task automatic fill_random();
        while (line_chars.size() < PHASE_ITEMS)
            add_line();
        push_char(8'($urandom_range(255)), 1'b1, 1'b1);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (line_chars.size() != 0 || in_valid);
        @(negedge clk);
        while (decoded_expect.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic [7:0] plan [7];
        plan = '{8'd0, 8'd1, 8'd3, 8'd255, 8'd0, 8'd2, 8'd255};
        plan[4] = 8'($urandom_range(4, 254));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_char(CH_COMMA, 1'b1, 1'b0);
        push_char(CH_SEMI, 1'b1, 1'b0);
        push_char(8'hFF, 1'b1, 1'b1);
        push_char(8'h00, 1'b1, 1'b0);
        push_char("a", 1'b0, 1'b0);
        push_char(CH_QUOTE, 1'b1, 1'b0);
        push_char(8'h00, 1'b0, 1'b0);
        push_char(CH_BSLASH, 1'b0, 1'b0);
        push_char("9", 1'b0, 1'b0);
        push_char("a", 1'b0, 1'b0);
        push_char(CH_BSLASH, 1'b0, 1'b0);
        push_char("F", 1'b0, 1'b0);
        push_char("0", 1'b0, 1'b0);
        push_char(8'hFF, 1'b0, 1'b0);
        push_char(CH_QUOTE, 1'b0, 1'b0);
        push_char(CH_COMMA, 1'b0, 1'b0);
        push_char(CH_QUOTE, 1'b1, 1'b0);
        push_char(CH_BSLASH, 1'b0, 1'b0);
        push_char("g", 1'b0, 1'b0);
        push_char(CH_QUOTE, 1'b1, 1'b0);
        push_char("q", 1'b0, 1'b0);
        push_char(CH_BSLASH, 1'b0, 1'b0);
        push_char("1", 1'b0, 1'b0);
        push_char("G", 1'b0, 1'b0);
        push_char(CH_QUOTE, 1'b1, 1'b0);
        push_char(CH_BSLASH, 1'b0, 1'b0);
        push_char(8'h00, 1'b0, 1'b1);
        push_char(CH_QUOTE, 1'b1, 1'b0);
        push_char("z", 1'b0, 1'b0);
        push_char(8'h0D, 1'b0, 1'b1);
        push_char(CH_QUOTE, 1'b1, 1'b0);
        push_char(CH_QUOTE, 1'b0, 1'b0);
        push_char(8'h0A, 1'b0, 1'b1);
        push_char(CH_QUOTE, 1'b1, 1'b0);
        push_char("a", 1'b0, 1'b0);
        push_char(CH_COMMA, 1'b1, 1'b0);
        fill_random();

        for (int k = 0; k < 7; k++)
        begin
            wait_drained();
            steady = 1'b0;
            repeat (3) @(negedge clk);
            cfg_write_en   <= 1'b1;
            cfg_write_data <= plan[k];
            @(negedge clk);
            cfg_write_en <= 1'b0;
            if (k == 1)
                rx_stall_req = 1'b1;
            if (k == 2)
                steady = 1'b1;
            if (plan[k] == 8'd255)
            begin
                add_string(255, 1'b1, 1'b1);
                push_char(8'h0D, 1'b0, 1'b1);
                add_string(258, 1'b1, 1'b1);
                push_char(8'h0D, 1'b0, 1'b1);
            end
            fill_random();
        end
        wait_drained();
        repeat (4) @(posedge clk);

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
